>>> sv/tctd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tctd_pkg;

  localparam int unsigned TICK_W  = 32;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MS_W    = 6;
  localparam int unsigned SET_W   = 6;
  localparam int unsigned DIV_W   = 10;

  localparam logic [TICK_W-1:0] LIMIT_RESET    = 32'h7FFF_FFFF;
  localparam logic [DIV_W-1:0]  TICKS_PER_SEC  = 10'd1000;
  localparam logic [SET_W-1:0]  MAX_HOUR       = 6'd23;
  localparam logic [SET_W-1:0]  MAX_MIN_SEC    = 6'd59;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_SET_TIME = 2'd1,
    ACT_ELAPSED  = 2'd2,
    ACT_STATUS   = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [SET_W-1:0]   set_hour;
    logic [SET_W-1:0]   set_minute;
    logic [SET_W-1:0]   set_second;
    logic [TICK_W-1:0]  past_tick;
  } in_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]  tick_now;
    logic [TICK_W-1:0]  overflows;
    logic [TICK_W-1:0]  elapsed_ticks;
    logic [HOUR_W-1:0]  hour_now;
    logic [MS_W-1:0]    minute_now;
    logic [MS_W-1:0]    second_now;
    logic               status;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/tctd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tctd_in_if;
  logic                valid;
  logic                ready;
  tctd_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tctd_out_if;
  logic                 valid;
  logic                 ready;
  tctd_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/tick_counter_time_of_day_clock.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake      payload
// in_ch     in         valid/ready    action, set_hour/minute/second, past_tick
// out_ch    out        valid/ready    tick_now, overflows, elapsed, h/m/s, status
// cfg       in         cfg_wr_en      cfg_wr_data = tick wrap limit
//
// one request per cycle unless out_ch stalls; a taken request passes through the
// input register, then state update and result register
// time of day is kept as hour/minute/second counters, so no division sits in the path
// rst_n is synchronous: clears counters, time of day, valids, limit to 0x7fffffff
// a stalled result holds while the input register still takes one more request

module tick_counter_time_of_day_clock (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tctd_pkg::TICK_W-1:0]   cfg_wr_data,
  tctd_in_if.sink                       in_ch,
  tctd_out_if.source                    out_ch
);
  import tctd_pkg::*;

  logic [TICK_W-1:0] limit_r;

  // input stage
  logic              a_valid_r;
  action_t           a_action_r;
  logic [SET_W-1:0]  a_hour_r;
  logic [SET_W-1:0]  a_min_r;
  logic [SET_W-1:0]  a_sec_r;
  logic [TICK_W-1:0] a_past_r;
  logic              a_past_gt_lim_r;
  logic [TICK_W-1:0] a_wrap_off_r;

  // block state
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [TICK_W-1:0] ovf_r, ovf_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [HOUR_W-1:0] hour_r, hour_nxt;
  logic [MS_W-1:0]   min_r, min_nxt;
  logic [MS_W-1:0]   sec_r, sec_nxt;

  // result stage
  logic              o_valid_r;
  out_item_t         o_data_r;

  logic              adv;
  logic              in_acc;
  logic              set_ok;
  logic [TICK_W-1:0] elapsed;

  assign adv          = a_valid_r && (!o_valid_r || out_ch.ready);
  assign in_ch.ready  = !a_valid_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = o_valid_r;
  assign out_ch.data  = o_data_r;

  assign set_ok = (a_hour_r <= MAX_HOUR) && (a_min_r <= MAX_MIN_SEC) &&
                  (a_sec_r <= MAX_MIN_SEC);

  always_comb begin
    if (a_past_gt_lim_r || (a_past_r == tick_r)) begin
      elapsed = '0;
    end else if (a_past_r < tick_r) begin
      elapsed = tick_r - a_past_r;
    end else begin
      // past snapshot lies before the last wrap
      elapsed = tick_r + a_wrap_off_r;
    end
  end

  always_comb begin
    tick_nxt = tick_r;
    ovf_nxt  = ovf_r;
    div_nxt  = div_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    unique case (a_action_r)
      ACT_TICK: begin
        if (tick_r >= limit_r) begin
          tick_nxt = '0;
          ovf_nxt  = ovf_r + 1'b1;
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
        if (div_r == TICKS_PER_SEC - 1'b1) begin
          div_nxt = '0;
          if (sec_r == MAX_MIN_SEC[MS_W-1:0]) begin
            sec_nxt = '0;
            if (min_r == MAX_MIN_SEC[MS_W-1:0]) begin
              min_nxt = '0;
              if (hour_r == MAX_HOUR[HOUR_W-1:0]) begin
                hour_nxt = '0;
              end else begin
                hour_nxt = hour_r + 1'b1;
              end
            end else begin
              min_nxt = min_r + 1'b1;
            end
          end else begin
            sec_nxt = sec_r + 1'b1;
          end
        end else begin
          div_nxt = div_r + 1'b1;
        end
      end
      ACT_SET_TIME: begin
        if (set_ok) begin
          hour_nxt = a_hour_r[HOUR_W-1:0];
          min_nxt  = a_min_r;
          sec_nxt  = a_sec_r;
        end
      end
      ACT_ELAPSED: begin
      end
      ACT_STATUS: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_action_r <= ACT_STATUS;
    end else if (in_acc) begin
      a_action_r      <= in_ch.data.action;
      a_hour_r        <= in_ch.data.set_hour;
      a_min_r         <= in_ch.data.set_minute;
      a_sec_r         <= in_ch.data.set_second;
      a_past_r        <= in_ch.data.past_tick;
      a_past_gt_lim_r <= in_ch.data.past_tick > limit_r;
      a_wrap_off_r    <= limit_r - in_ch.data.past_tick + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      ovf_r  <= '0;
      div_r  <= '0;
      hour_r <= '0;
      min_r  <= '0;
      sec_r  <= '0;
    end else if (adv) begin
      tick_r <= tick_nxt;
      ovf_r  <= ovf_nxt;
      div_r  <= div_nxt;
      hour_r <= hour_nxt;
      min_r  <= min_nxt;
      sec_r  <= sec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (adv) begin
      o_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_data_r.tick_now      <= tick_nxt;
      o_data_r.overflows     <= ovf_nxt;
      o_data_r.elapsed_ticks <= (a_action_r == ACT_ELAPSED) ? elapsed : '0;
      o_data_r.hour_now      <= hour_nxt;
      o_data_r.minute_now    <= min_nxt;
      o_data_r.second_now    <= sec_nxt;
      o_data_r.status        <= (a_action_r == ACT_SET_TIME) && !set_ok;
    end
  end

endmodule

`default_nettype wire

>>> sv/tctd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tctd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input tctd_pkg::out_item_t  out_data
);
  import tctd_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hour_now <= MAX_HOUR[HOUR_W-1:0]) &&
                  (out_data.minute_now <= MAX_MIN_SEC[MS_W-1:0]) &&
                  (out_data.second_now <= MAX_MIN_SEC[MS_W-1:0]))
    else $error("time of day out of range");

  // an invalid set time never carries an elapsed count
  a_status_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.elapsed_ticks == '0)
    else $error("status set with nonzero elapsed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind tick_counter_time_of_day_clock tctd_checker u_tctd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

>>> verif/tick_counter_time_of_day_clock_test.sv
`timescale 1ns / 1ps

module tick_counter_time_of_day_clock_test;
  import tctd_pkg::*;

  localparam int unsigned DAY_SEC  = 86400;
  localparam int unsigned HOUR_SEC = 3600;
  localparam int unsigned MIN_SEC  = 60;
  localparam int unsigned IDLE_PCT = 38;
  localparam int unsigned SETTLE   = 6;

  typedef enum logic [1:0] {
    GEN_TABLE,
    GEN_MIXED,
    GEN_ROLLOVER
  } gen_mode_t;

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t res;
  } table_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [TICK_W-1:0] cfg_wr_data;

  tctd_in_if  in_ch ();
  tctd_out_if out_ch ();

  tick_counter_time_of_day_clock u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the timer state
  logic [TICK_W-1:0] limit_shadow = LIMIT_RESET;
  logic [TICK_W-1:0] ticks_shadow = '0;
  logic [TICK_W-1:0] wraps_shadow = '0;
  int unsigned       ms_shadow    = 0;
  int unsigned       sod_shadow   = 0;

  out_item_t   due_results[$];
  table_row_t  table_rows[$];
  out_item_t   predicted;
  out_item_t   row_result;
  out_item_t   want;
  logic        row_typed = 1'b0;
  int unsigned row_idx = 0;
  int unsigned requests_left = 0;
  int unsigned bad_count = 0;
  gen_mode_t   gen_mode = GEN_TABLE;
  logic        calm = 1'b0;
  logic        rollover_armed = 1'b0;
  logic [SET_W-1:0] rollover_hour = '0;

  function automatic out_item_t clock_model_step(input in_item_t req);
    out_item_t res;
    res = '0;
    case (req.action)
      ACT_TICK: begin
        if (ticks_shadow >= limit_shadow) begin
          ticks_shadow = '0;
          wraps_shadow = wraps_shadow + 1;
        end else begin
          ticks_shadow = ticks_shadow + 1;
        end
        ms_shadow = ms_shadow + 1;
        if (ms_shadow >= TICKS_PER_SEC) begin
          ms_shadow = 0;
          sod_shadow = (sod_shadow < DAY_SEC - 1) ? sod_shadow + 1 : 0;
        end
      end
      ACT_SET_TIME: begin
        if (req.set_hour > MAX_HOUR || req.set_minute > MAX_MIN_SEC ||
            req.set_second > MAX_MIN_SEC) begin
          res.status = 1'b1;
        end else begin
          sod_shadow = req.set_hour * HOUR_SEC + req.set_minute * MIN_SEC + req.set_second;
        end
      end
      ACT_ELAPSED: begin
        if (req.past_tick > limit_shadow || req.past_tick == ticks_shadow) begin
          res.elapsed_ticks = '0;
        end else if (req.past_tick < ticks_shadow) begin
          res.elapsed_ticks = ticks_shadow - req.past_tick;
        end else begin
          // snapshot taken before the last wrap
          res.elapsed_ticks = limit_shadow - req.past_tick + ticks_shadow + 1;
        end
      end
      ACT_STATUS: ;
    endcase
    res.tick_now   = ticks_shadow;
    res.overflows  = wraps_shadow;
    res.hour_now   = HOUR_W'(sod_shadow / HOUR_SEC);
    res.minute_now = MS_W'((sod_shadow % HOUR_SEC) / MIN_SEC);
    res.second_now = MS_W'(sod_shadow % MIN_SEC);
    return res;
  endfunction

  function automatic out_item_t glance(input logic [TICK_W-1:0] ticks,
                                       input logic [TICK_W-1:0] elapsed,
                                       input int unsigned hh, input int unsigned mm,
                                       input int unsigned ss, input logic bad);
    out_item_t res;
    res.tick_now      = ticks;
    res.overflows     = '0;
    res.elapsed_ticks = elapsed;
    res.hour_now      = HOUR_W'(hh);
    res.minute_now    = MS_W'(mm);
    res.second_now    = MS_W'(ss);
    res.status        = bad;
    return res;
  endfunction

  task automatic add_row(input action_t act, input logic [SET_W-1:0] hh,
                         input logic [SET_W-1:0] mm, input logic [SET_W-1:0] ss,
                         input logic [TICK_W-1:0] past, input logic typed,
                         input out_item_t res);
    table_row_t row;
    row.req.action     = act;
    row.req.set_hour   = hh;
    row.req.set_minute = mm;
    row.req.set_second = ss;
    row.req.past_tick  = past;
    row.typed          = typed;
    row.res            = res;
    table_rows.push_back(row);
  endtask

  function automatic in_item_t random_request();
    in_item_t req;
    req.action     = action_t'($urandom_range(3));
    req.set_hour   = SET_W'($urandom);
    req.set_minute = SET_W'($urandom);
    req.set_second = SET_W'($urandom);
    req.past_tick  = $urandom;
    return req;
  endfunction

  function automatic logic [TICK_W-1:0] pick_past();
    case ($urandom_range(7))
      0: return ticks_shadow;
      1: return ticks_shadow - $urandom_range(3);
      2: return limit_shadow;
      3: return limit_shadow + 1;
      4: return $urandom;
      5: return (&limit_shadow) ? $urandom : $urandom_range(limit_shadow);
      6: return ticks_shadow + 1 + $urandom_range(7);
      default: return '0;
    endcase
  endfunction

  function automatic in_item_t pick_set_time(input in_item_t req);
    case ($urandom_range(9))
      0: begin
        req.set_hour   = MAX_HOUR;
        req.set_minute = MAX_MIN_SEC;
        req.set_second = MAX_MIN_SEC;
      end
      1: begin
        req.set_hour   = SET_W'($urandom_range(23));
        req.set_minute = MAX_MIN_SEC;
        req.set_second = MAX_MIN_SEC;
      end
      2: begin
        req.set_hour   = '0;
        req.set_minute = '0;
        req.set_second = '0;
      end
      3, 4: begin
        // mostly out of range in at least one field
        req.set_hour   = SET_W'($urandom_range(63));
        req.set_minute = SET_W'($urandom_range(63));
        req.set_second = SET_W'($urandom_range(63));
      end
      default: begin
        req.set_hour   = SET_W'($urandom_range(23));
        req.set_minute = SET_W'($urandom_range(59));
        req.set_second = SET_W'($urandom_range(59));
      end
    endcase
    return req;
  endfunction

  function automatic in_item_t next_mixed();
    in_item_t    req;
    int unsigned roll;
    req  = random_request();
    roll = $urandom_range(99);
    if (roll < 45) begin
      req.action = ACT_TICK;
    end else if (roll < 70) begin
      req.action    = ACT_ELAPSED;
      req.past_tick = pick_past();
    end else if (roll < 90) begin
      req.action = ACT_SET_TIME;
      req        = pick_set_time(req);
    end else begin
      req.action = ACT_STATUS;
    end
    return req;
  endfunction

  // park the clock just before a carry, then tick through it
  function automatic in_item_t next_rollover();
    in_item_t    req;
    int unsigned roll;
    req = random_request();
    if (rollover_armed) begin
      rollover_armed = 1'b0;
      req.action     = ACT_SET_TIME;
      req.set_hour   = rollover_hour;
      req.set_minute = MAX_MIN_SEC;
      req.set_second = MAX_MIN_SEC;
    end else begin
      roll = $urandom_range(99);
      if (roll < 93) begin
        req.action = ACT_TICK;
      end else if (roll < 97) begin
        req.action    = ACT_ELAPSED;
        req.past_tick = pick_past();
      end else begin
        req.action = ACT_STATUS;
      end
    end
    return req;
  endfunction

  task automatic report_mismatch(input string what, input logic [TICK_W-1:0] got,
                                 input logic [TICK_W-1:0] exp_val);
    bad_count++;
    $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, exp_val);
  endtask

  // request side: predict on acceptance, then pick the next request
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      predicted = clock_model_step(in_ch.data);
      due_results.push_back(row_typed ? row_result : predicted);
    end
    if (!in_ch.valid || in_ch.ready) begin
      if (requests_left != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        row_typed = 1'b0;
        case (gen_mode)
          GEN_TABLE: begin
            in_ch.data <= table_rows[row_idx].req;
            row_typed  = table_rows[row_idx].typed;
            row_result = table_rows[row_idx].res;
            row_idx++;
          end
          GEN_MIXED: in_ch.data <= next_mixed();
          default:   in_ch.data <= next_rollover();
        endcase
        requests_left--;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, tick_now", out_ch.data.tick_now, '0);
      end else begin
        want = due_results.pop_front();
        if (out_ch.data.tick_now !== want.tick_now)
          report_mismatch("tick_now", out_ch.data.tick_now, want.tick_now);
        if (out_ch.data.overflows !== want.overflows)
          report_mismatch("overflows", out_ch.data.overflows, want.overflows);
        if (out_ch.data.elapsed_ticks !== want.elapsed_ticks)
          report_mismatch("elapsed_ticks", out_ch.data.elapsed_ticks, want.elapsed_ticks);
        if (out_ch.data.hour_now !== want.hour_now)
          report_mismatch("hour_now", TICK_W'(out_ch.data.hour_now),
                          TICK_W'(want.hour_now));
        if (out_ch.data.minute_now !== want.minute_now)
          report_mismatch("minute_now", TICK_W'(out_ch.data.minute_now),
                          TICK_W'(want.minute_now));
        if (out_ch.data.second_now !== want.second_now)
          report_mismatch("second_now", TICK_W'(out_ch.data.second_now),
                          TICK_W'(want.second_now));
        if (out_ch.data.status !== want.status)
          report_mismatch("status", TICK_W'(out_ch.data.status), TICK_W'(want.status));
      end
    end
    out_ch.ready <= calm || $urandom_range(99) >= IDLE_PCT;
  end

  task automatic write_limit(input logic [TICK_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_shadow = value;
  endtask

  task automatic run_phase(input gen_mode_t mode, input int unsigned count, input logic quiet);
    @(negedge clk);
    gen_mode       = mode;
    calm           = quiet;
    rollover_armed = 1'b1;
    requests_left  = count;
    while (requests_left != 0 || in_ch.valid || due_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;

    add_row(ACT_STATUS,    0,  0,  0, '0,            1, glance(0, 0, 0, 0, 0, 0));
    add_row(ACT_TICK,      0,  0,  0, '0,            1, glance(1, 0, 0, 0, 0, 0));
    add_row(ACT_ELAPSED,   0,  0,  0, 32'd0,         1, glance(1, 1, 0, 0, 0, 0));
    add_row(ACT_ELAPSED,   0,  0,  0, 32'd1,         1, glance(1, 0, 0, 0, 0, 0));
    add_row(ACT_ELAPSED,   0,  0,  0, '1,            1, glance(1, 0, 0, 0, 0, 0));
    add_row(ACT_ELAPSED,   0,  0,  0, LIMIT_RESET,   1, glance(1, 2, 0, 0, 0, 0));
    add_row(ACT_ELAPSED,   0,  0,  0, 32'h8000_0000, 1, glance(1, 0, 0, 0, 0, 0));
    add_row(ACT_ELAPSED,   0,  0,  0, 32'h5555_5555, 0, '0);
    add_row(ACT_SET_TIME, 23, 59, 59, '0,            1, glance(1, 0, 23, 59, 59, 0));
    add_row(ACT_SET_TIME, 24,  0,  0, '0,            1, glance(1, 0, 23, 59, 59, 1));
    add_row(ACT_SET_TIME,  0, 60,  0, '0,            1, glance(1, 0, 23, 59, 59, 1));
    add_row(ACT_SET_TIME,  0,  0, 60, '0,            1, glance(1, 0, 23, 59, 59, 1));
    add_row(ACT_SET_TIME, 63, 63, 63, '1,            1, glance(1, 0, 23, 59, 59, 1));
    add_row(ACT_SET_TIME, 42, 21, 21, '0,            1, glance(1, 0, 23, 59, 59, 1));
    add_row(ACT_SET_TIME,  0,  0,  0, '0,            1, glance(1, 0, 0, 0, 0, 0));
    add_row(ACT_SET_TIME, 21, 21, 42, '0,            1, glance(1, 0, 21, 21, 42, 0));
    add_row(ACT_TICK,     63, 63, 63, '1,            1, glance(2, 0, 21, 21, 42, 0));
    add_row(ACT_STATUS,   63, 63, 63, '1,            1, glance(2, 0, 21, 21, 42, 0));
    add_row(ACT_ELAPSED,  63, 63, 63, 32'd2,         1, glance(2, 0, 21, 21, 42, 0));
    add_row(ACT_ELAPSED,   0,  0,  0, 32'd1,         1, glance(2, 1, 21, 21, 42, 0));
    add_row(ACT_ELAPSED,   0,  0,  0, 32'h7FFF_FFFE, 0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(GEN_TABLE, table_rows.size(), 1'b0);
    run_phase(GEN_MIXED, 200, 1'b0);
    write_limit('1);
    run_phase(GEN_MIXED, 120, 1'b0);
    // zero limit: every tick wraps
    write_limit('0);
    run_phase(GEN_MIXED, 100, 1'b0);
    write_limit(32'd1);
    run_phase(GEN_MIXED, 100, 1'b0);
    write_limit(32'd150);
    run_phase(GEN_MIXED, 200, 1'b0);
    // count is usually left above the new limit here
    write_limit(32'd7);
    run_phase(GEN_MIXED, 150, 1'b1);
    write_limit($urandom);
    rollover_hour = MAX_HOUR;
    run_phase(GEN_ROLLOVER, 1050, 1'b0);

    if (bad_count == 0) begin
      $display("** tick_counter_time_of_day_clock: PASSED **");
    end else begin
      $display("** tick_counter_time_of_day_clock: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** tick_counter_time_of_day_clock: FAILED **");
    $finish;
  end

endmodule
